// ===== sv/tos_pkg.sv =====
// Shared types and constants for the TCP option scrubber.
package tos_pkg;

   localparam int MAX_OPTION_BYTES_DEFAULT = 40;
   localparam int COUNT_W = 6;

   localparam logic [7:0] NOP_BYTE    = 8'h01;
   localparam logic [7:0] KIND_EOL    = 8'd0;
   localparam logic [7:0] KIND_NOP    = 8'd1;
   localparam logic [7:0] KIND_WSCALE = 8'd3;
   localparam logic [7:0] KIND_SACK   = 8'd5;
   localparam logic [7:0] KIND_MPTCP  = 8'd30;
   localparam logic [7:0] SUBTYPE_MASK = 8'hf0;
   localparam logic [7:0] MIN_LENGTH  = 8'd2;

   typedef enum logic [1:0] {
      PH_KIND = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ACT_PASS  = 2'd0,
      ACT_SCRUB = 2'd1,
      ACT_MPTCP = 2'd2
   } action_type;

   typedef struct packed {
      logic       malformed;
      logic [3:0] mptcp_subtype;
      logic       mptcp_seen;
      logic       out_last;
      logic [7:0] out_byte;
   } result_type;

endpackage

// ===== sv/tcp_option_scrubber.sv =====
// Top level of the TCP option scrubber: stream ports and result register.
//
// The req_ channel takes the TCP option area one byte per transfer, with
// req_tlast on the final byte. Each accepted byte yields exactly one transfer
// on the rsp_ channel: the byte unchanged, or NOP when it belongs to a
// window-scale or SACK option, plus the running MPTCP and malformed flags.
// The transfer for the final byte carries rsp_tlast and the area summary.
// rsp_tvalid rises in the cycle after a byte is accepted. Throughput is
// one byte per cycle while the receiver keeps up: the parse update is a
// single pass of logic between parse state and the rsp_ output register.
// When the receiver stalls, the result stays in the output register and
// req_tready drops until that result is taken; req_tready is high again in
// the cycle the pending result transfers.
// Reset (synchronous, active high) empties the output register and returns
// the parser to the start of an area. After each final byte the parser
// returns to that state by itself.
module tcp_option_scrubber #(
   parameter int MAX_OPTION_BYTES = tos_pkg::MAX_OPTION_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] option_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // out_last
   output logic [7:0] rsp_tuser    // [0] mptcp_seen, [4:1] mptcp_subtype, [5] malformed
);

   tos_pkg::result_type result;
   tos_pkg::result_type rsp_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   tos_parser #(
      .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (req_fire),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.out_byte;
   assign rsp_tlast  = rsp_ff.out_last;
   assign rsp_tuser  = {2'b00, rsp_ff.malformed, rsp_ff.mptcp_subtype, rsp_ff.mptcp_seen};

`ifndef ASSERT_OFF
   // every accepted byte shows up as a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted byte produced no result");

   // the final byte's result carries tlast, and only that one
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_tlast == $past(req_tlast)))
      else $error("rsp_tlast does not follow req_tlast");

   // an empty output register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

   // a scrubbed byte is always NOP
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (result.out_byte != req_tdata) |=> rsp_tdata == tos_pkg::NOP_BYTE)
      else $error("rewritten byte is not NOP");
`endif

endmodule

// ===== sv/tos_parser.sv =====
// Option walker: parse state registers and per-byte rewrite logic.
module tos_parser #(
   parameter int MAX_OPTION_BYTES = tos_pkg::MAX_OPTION_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output tos_pkg::result_type result
);

   localparam logic [7:0] MAX_LEN = 8'(MAX_OPTION_BYTES);

   tos_pkg::phase_type  phase_ff, phase_in;
   tos_pkg::action_type action_ff, action_in;
   logic [tos_pkg::COUNT_W-1:0] bytes_left_ff, bytes_left_in;
   logic [tos_pkg::COUNT_W-1:0] byte_idx_ff, byte_idx_in;
   logic       seen_ff, seen_in;
   logic [3:0] subtype_ff, subtype_in;
   logic       error_ff, error_in;
   logic [7:0] out_byte;
   logic [7:0] len_less2;

   always_comb begin
      phase_in      = phase_ff;
      action_in     = action_ff;
      bytes_left_in = bytes_left_ff;
      byte_idx_in   = byte_idx_ff;
      seen_in       = seen_ff;
      subtype_in    = subtype_ff;
      error_in      = error_ff;
      out_byte      = in_byte;
      len_less2     = in_byte - tos_pkg::MIN_LENGTH;

      case (phase_ff)
         tos_pkg::PH_KIND: begin
            if (in_byte == tos_pkg::KIND_EOL) begin
               phase_in = tos_pkg::PH_DONE;
            end else if (in_byte != tos_pkg::KIND_NOP) begin
               if (in_byte == tos_pkg::KIND_WSCALE || in_byte == tos_pkg::KIND_SACK) begin
                  action_in = tos_pkg::ACT_SCRUB;
                  out_byte  = tos_pkg::NOP_BYTE;
               end else if (in_byte == tos_pkg::KIND_MPTCP) begin
                  action_in = tos_pkg::ACT_MPTCP;
               end else begin
                  action_in = tos_pkg::ACT_PASS;
               end
               byte_idx_in = tos_pkg::COUNT_W'(1);
               phase_in    = tos_pkg::PH_LEN;
               if (in_last) error_in = 1'b1;
            end
         end
         tos_pkg::PH_LEN: begin
            if (in_byte < tos_pkg::MIN_LENGTH || in_byte > MAX_LEN) begin
               error_in = 1'b1;
               phase_in = tos_pkg::PH_DONE;
            end else begin
               bytes_left_in = len_less2[tos_pkg::COUNT_W-1:0];
               if (action_ff == tos_pkg::ACT_SCRUB) out_byte = tos_pkg::NOP_BYTE;
               byte_idx_in = tos_pkg::COUNT_W'(2);
               phase_in = (bytes_left_in != '0) ? tos_pkg::PH_BODY : tos_pkg::PH_KIND;
               if (in_last && bytes_left_in != '0) error_in = 1'b1;
            end
         end
         tos_pkg::PH_BODY: begin
            if (action_ff == tos_pkg::ACT_SCRUB) out_byte = tos_pkg::NOP_BYTE;
            // third byte of an MPTCP option carries the subtype nibble
            if (action_ff == tos_pkg::ACT_MPTCP && byte_idx_ff == tos_pkg::COUNT_W'(2)) begin
               subtype_in = 4'((in_byte & tos_pkg::SUBTYPE_MASK) >> 4);
               seen_in    = 1'b1;
            end
            byte_idx_in   = byte_idx_ff + tos_pkg::COUNT_W'(1);
            bytes_left_in = bytes_left_ff - tos_pkg::COUNT_W'(1);
            if (bytes_left_in == '0) begin
               phase_in = tos_pkg::PH_KIND;
            end else if (in_last) begin
               error_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      result.out_byte      = out_byte;
      result.out_last      = in_last;
      result.mptcp_seen    = seen_in;
      result.mptcp_subtype = subtype_in;
      result.malformed     = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && in_last)) begin
         phase_ff      <= tos_pkg::PH_KIND;
         action_ff     <= tos_pkg::ACT_PASS;
         bytes_left_ff <= '0;
         byte_idx_ff   <= '0;
         seen_ff       <= 1'b0;
         subtype_ff    <= '0;
         error_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         action_ff     <= action_in;
         bytes_left_ff <= bytes_left_in;
         byte_idx_ff   <= byte_idx_in;
         seen_ff       <= seen_in;
         subtype_ff    <= subtype_in;
         error_ff      <= error_in;
      end
   end

endmodule
